// ===== sv/frtt_pkg.sv =====
// ----------------------------------------------------------------------------
// Fractional-rate tick timer package
// Shared types, constants and helpers for the tick timer core and its divider.
// ----------------------------------------------------------------------------
package frtt_pkg;

  localparam int NUM_CHANNELS = 3;
  localparam int COUNTER_BITS = 24;
  localparam int CH_W         = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 16;
  localparam int VALUE_W      = 16;

  localparam logic [VALUE_W-1:0]      TICK_RATE = 16'd32768;
  localparam logic [COUNTER_BITS-1:0] MIN_DELAY = COUNTER_BITS'(3);
  localparam logic [COUNTER_BITS-1:0] CMASK     = {COUNTER_BITS{1'b1}};

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CH0  = 2'd1;

  typedef enum logic [2:0] {
    ACT_TICK       = 3'd0,
    ACT_LOAD_EPOCH = 3'd1,
    ACT_ARM        = 3'd2,
    ACT_STOP       = 3'd3,
    ACT_READ       = 3'd4
  } action_t;

  typedef struct packed {
    logic [2:0]  action;
    logic [31:0] epoch_value;
    logic [23:0] target_tick;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  periodic_fired;
    logic        second_fired;
    logic        oneshot_fired;
    logic [31:0] epoch_seconds;
    logic [14:0] sub_second_ticks;
    logic [31:0] tick_count;
  } out_item_t;

  // Request to and response from the period divider.
  typedef struct packed {
    logic               start;
    logic               abort;
    logic [VALUE_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic               busy;
    logic               done;
    logic [VALUE_W-1:0] quotient;
    logic [VALUE_W-1:0] remainder;
  } div_rsp_t;

  // A rate above the tick rate is treated as the tick rate.
  function automatic logic [VALUE_W-1:0] clamp_rate(input logic [VALUE_W-1:0] v);
    logic [VALUE_W-1:0] r;
    r = (v > TICK_RATE) ? TICK_RATE : v;
    return r;
  endfunction

endpackage

// ===== sv/frtt_div.sv =====
// ----------------------------------------------------------------------------
// Period divider
// Restoring division of the tick rate by a rate, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module frtt_div (
  input  logic               clk,
  input  logic               rst_n,
  input  frtt_pkg::div_req_t req,
  output frtt_pkg::div_rsp_t rsp
);

  localparam int CNT_W = $clog2(frtt_pkg::VALUE_W);

  logic                         busy_r;
  logic                         done_r;
  logic [CNT_W-1:0]             cnt_r;
  logic [frtt_pkg::VALUE_W-1:0] rem_r;
  logic [frtt_pkg::VALUE_W-1:0] quot_r;
  logic [frtt_pkg::VALUE_W-1:0] div_r;

  logic [frtt_pkg::VALUE_W:0]   shifted;
  logic [frtt_pkg::VALUE_W:0]   diff;
  logic                         ge;

  always_comb begin
    shifted = {rem_r, frtt_pkg::TICK_RATE[cnt_r]};
    ge      = (shifted >= {1'b0, div_r});
    diff    = shifted - {1'b0, div_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else if (req.abort) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else if (req.start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
    end else if (busy_r) begin
      busy_r <= (cnt_r != '0);
      done_r <= (cnt_r == '0);
    end else begin
      done_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      cnt_r  <= CNT_W'(frtt_pkg::VALUE_W - 1);
      rem_r  <= '0;
      quot_r <= '0;
      div_r  <= req.divisor;
    end else if (busy_r) begin
      cnt_r  <= cnt_r - 1'b1;
      rem_r  <= ge ? diff[frtt_pkg::VALUE_W-1:0] : shifted[frtt_pkg::VALUE_W-1:0];
      quot_r <= {quot_r[frtt_pkg::VALUE_W-2:0], ge};
    end
  end

  assign rsp.busy      = busy_r;
  assign rsp.done      = done_r;
  assign rsp.quotient  = quot_r;
  assign rsp.remainder = rem_r;

endmodule

// ===== sv/fractional_rate_tick_timer_core.sv =====
// A result is held in the output register from the cycle after its item is accepted.
// Throughput: one item per cycle while the consumer keeps up and no configuration
// write or derivation holds items off; the output register is refilled in the same
// cycle it is emptied. A configuration write holds off items while the periods are
// re-derived: interval channels directly, rate channels by start, 16 divider steps, apply.
// Reset (synchronous, active low) clears all timer state; no clearing pass is needed.
// ----------------------------------------------------------------------------
// Fractional-rate tick timer core
// A 24-bit tick counter with three periodic channels in interval or rate mode,
// a seconds channel that advances the epoch and a one-shot compare.
// ----------------------------------------------------------------------------
module fractional_rate_tick_timer_core (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  frtt_pkg::in_item_t                 in_data,
  output logic                               out_valid,
  input  logic                               out_ready,
  output frtt_pkg::out_item_t                out_data,
  input  logic                               cfg_we,
  input  logic [frtt_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [frtt_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int NC = frtt_pkg::NUM_CHANNELS;
  localparam int CB = frtt_pkg::COUNTER_BITS;
  localparam int VW = frtt_pkg::VALUE_W;

  // --------------------------------------------------------------------------
  // Timer state
  // --------------------------------------------------------------------------
  logic [CB-1:0]        cnt_r,      cnt_nxt;
  logic [CB-1:0]        cmp_r   [NC];
  logic [CB-1:0]        cmp_nxt [NC];
  logic [VW-1:0]        acc_r   [NC];
  logic [VW-1:0]        acc_nxt [NC];
  logic [VW-1:0]        short_r [NC];
  logic [VW-1:0]        short_nxt [NC];
  logic [VW-1:0]        err_r   [NC];
  logic [VW-1:0]        err_nxt [NC];
  logic [VW-1:0]        value_r [NC];
  logic [VW-1:0]        value_nxt [NC];
  logic [NC-1:0]        mode_r,     mode_nxt;
  logic [CB-1:0]        sec_cmp_r,  sec_cmp_nxt;
  logic [31:0]          epoch_r,    epoch_nxt;
  logic [CB-1:0]        os_cmp_r,   os_cmp_nxt;
  logic                 os_armed_r, os_armed_nxt;

  // Channels whose derived period is stale after a configuration write.
  logic [NC-1:0]        pend_r,     pend_nxt;
  logic [frtt_pkg::CH_W-1:0] cur_r, cur_nxt;

  logic                 out_valid_r;
  frtt_pkg::out_item_t  out_data_r;
  frtt_pkg::out_item_t  res;

  frtt_pkg::div_req_t   div_req;
  frtt_pkg::div_rsp_t   div_rsp;

  logic                 in_fire;

  // --------------------------------------------------------------------------
  // Divider used to split the tick rate into a short period and an error
  // --------------------------------------------------------------------------
  frtt_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // Items are held off while any channel still needs its period derived, and
  // while a configuration write is in flight.
  assign in_ready = (pend_r == '0) && !cfg_we && (!out_valid_r || out_ready);
  assign in_fire  = in_valid && in_ready;

  // --------------------------------------------------------------------------
  // Derivation sequencer: picks the lowest stale channel. An interval channel
  // (or a disabled one) is settled directly, without the divider; a rate channel runs the
  // divider and is settled when it reports done. Any configuration write
  // aborts the divider and the stale channels are simply done again, which
  // gives the same result because a derivation overwrites the whole channel
  // and the counter cannot move while items are held off.
  // --------------------------------------------------------------------------
  logic                      pick_found;
  logic [frtt_pkg::CH_W-1:0] pick_ch;
  logic [VW-1:0]             pick_val;
  logic                      pick_rate;
  logic                      apply_en;
  logic [frtt_pkg::CH_W-1:0] apply_ch;
  logic [VW-1:0]             apply_short;
  logic [VW-1:0]             apply_err;

  always_comb begin
    pick_found = (pend_r != '0);
    pick_ch    = '0;
    for (int c = NC - 1; c >= 0; c--) begin
      if (pend_r[c]) begin
        pick_ch = frtt_pkg::CH_W'(c);
      end
    end
    pick_val  = value_r[pick_ch];
    pick_rate = mode_r[pick_ch] && (pick_val != '0);

    apply_en        = 1'b0;
    apply_ch        = pick_ch;
    apply_short     = pick_val;
    apply_err       = '0;
    cur_nxt         = cur_r;
    div_req.start   = 1'b0;
    div_req.abort   = cfg_we;
    div_req.divisor = frtt_pkg::clamp_rate(pick_val);

    if (cfg_we) begin
      apply_en = 1'b0;
    end else if (div_rsp.done) begin
      apply_en    = 1'b1;
      apply_ch    = cur_r;
      apply_short = div_rsp.quotient;
      apply_err   = div_rsp.remainder;
    end else if (!div_rsp.busy && pick_found) begin
      if (pick_rate) begin
        div_req.start = 1'b1;
        cur_nxt       = pick_ch;
      end else begin
        apply_en = 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Next state of the timer for an accepted item, a derivation or a
  // configuration write. These never coincide with an accepted item.
  // --------------------------------------------------------------------------
  logic [NC-1:0]   fired;
  logic            sec_hit;
  logic            os_hit;
  logic [VW-1:0]   rate_c;
  logic [VW-1:0]   acc_sum;
  logic [VW:0]     period;
  logic [CB-1:0]   delay;
  logic [CB-1:0]   elapsed;

  always_comb begin
    cnt_nxt      = cnt_r;
    sec_cmp_nxt  = sec_cmp_r;
    epoch_nxt    = epoch_r;
    os_cmp_nxt   = os_cmp_r;
    os_armed_nxt = os_armed_r;
    mode_nxt     = mode_r;
    pend_nxt     = pend_r;
    fired        = '0;
    sec_hit      = 1'b0;
    os_hit       = 1'b0;
    delay        = in_data.target_tick - cnt_r;
    rate_c       = '0;
    acc_sum      = '0;
    period       = '0;
    for (int c = 0; c < NC; c++) begin
      cmp_nxt[c]   = cmp_r[c];
      acc_nxt[c]   = acc_r[c];
      short_nxt[c] = short_r[c];
      err_nxt[c]   = err_r[c];
      value_nxt[c] = value_r[c];
    end

    // Configuration writes only record the value and mark channels stale.
    if (cfg_we) begin
      if (cfg_index == frtt_pkg::REG_MODE) begin
        mode_nxt = cfg_data[NC-1:0];
        pend_nxt = '1;
      end
      for (int c = 0; c < NC; c++) begin
        if (cfg_index == frtt_pkg::CFG_IDX_W'(c + 1)) begin
          value_nxt[c] = cfg_data[VW-1:0];
          pend_nxt[c]  = 1'b1;
        end
      end
    end

    if (apply_en) begin
      pend_nxt[apply_ch] = 1'b0;
      acc_nxt[apply_ch]  = '0;
      if (value_r[apply_ch] == '0) begin
        short_nxt[apply_ch] = '0;
        err_nxt[apply_ch]   = '0;
        cmp_nxt[apply_ch]   = frtt_pkg::CMASK;
      end else begin
        short_nxt[apply_ch] = apply_short;
        err_nxt[apply_ch]   = apply_err;
        cmp_nxt[apply_ch]   = cnt_r + CB'(apply_short);
      end
    end

    if (in_fire) begin
      case (in_data.action)
        frtt_pkg::ACT_TICK: begin
          cnt_nxt = cnt_r + 1'b1;
          // Each channel fires when its compare meets the advanced counter; in
          // rate mode the error accumulator stretches every so often a period
          // by one tick so that the rate averages out exactly.
          for (int c = 0; c < NC; c++) begin
            if ((value_r[c] != '0) && (cmp_r[c] == cnt_nxt)) begin
              fired[c] = 1'b1;
              period   = {1'b0, short_r[c]};
              if (err_r[c] != '0) begin
                rate_c  = frtt_pkg::clamp_rate(value_r[c]);
                acc_sum = acc_r[c] + err_r[c];
                if (acc_sum >= rate_c) begin
                  acc_nxt[c] = acc_sum - rate_c;
                  period     = period + 1'b1;
                end else begin
                  acc_nxt[c] = acc_sum;
                end
              end
              cmp_nxt[c] = cmp_r[c] + CB'(period);
            end
          end
          if (sec_cmp_r == cnt_nxt) begin
            sec_hit     = 1'b1;
            sec_cmp_nxt = sec_cmp_r + CB'(frtt_pkg::TICK_RATE);
            epoch_nxt   = epoch_r + 1'b1;
          end
          if (os_armed_r && (os_cmp_r == cnt_nxt)) begin
            os_hit       = 1'b1;
            os_armed_nxt = 1'b0;
          end
        end
        frtt_pkg::ACT_LOAD_EPOCH: begin
          epoch_nxt   = in_data.epoch_value;
          sec_cmp_nxt = cnt_r + CB'(frtt_pkg::TICK_RATE);
        end
        frtt_pkg::ACT_ARM: begin
          // A target too close to now is pushed out to the minimum delay.
          if (delay > frtt_pkg::MIN_DELAY) begin
            os_cmp_nxt = in_data.target_tick;
          end else begin
            os_cmp_nxt = cnt_r + frtt_pkg::MIN_DELAY;
          end
          os_armed_nxt = 1'b1;
        end
        frtt_pkg::ACT_STOP: begin
          os_armed_nxt = 1'b0;
        end
        default: begin
          // A read, or an unused action code, leaves the state as it is.
          os_armed_nxt = os_armed_r;
        end
      endcase
    end

    // The time fields reflect the state after the item.
    elapsed                  = CB'(frtt_pkg::TICK_RATE) + cnt_nxt - sec_cmp_nxt;
    res.periodic_fired       = fired;
    res.second_fired         = sec_hit;
    res.oneshot_fired        = os_hit;
    res.epoch_seconds        = epoch_nxt + 32'(elapsed[CB-1:15]);
    res.sub_second_ticks     = elapsed[14:0];
    res.tick_count           = {epoch_nxt[16:0], 15'd0} + 32'(elapsed);
  end

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      sec_cmp_r   <= CB'(frtt_pkg::TICK_RATE);
      epoch_r     <= '0;
      os_cmp_r    <= '0;
      os_armed_r  <= 1'b0;
      mode_r      <= '0;
      pend_r      <= '0;
      out_valid_r <= 1'b0;
      for (int c = 0; c < NC; c++) begin
        cmp_r[c]   <= frtt_pkg::CMASK;
        acc_r[c]   <= '0;
        short_r[c] <= '0;
        err_r[c]   <= '0;
        value_r[c] <= '0;
      end
    end else begin
      cnt_r      <= cnt_nxt;
      sec_cmp_r  <= sec_cmp_nxt;
      epoch_r    <= epoch_nxt;
      os_cmp_r   <= os_cmp_nxt;
      os_armed_r <= os_armed_nxt;
      mode_r     <= mode_nxt;
      pend_r     <= pend_nxt;
      for (int c = 0; c < NC; c++) begin
        cmp_r[c]   <= cmp_nxt[c];
        acc_r[c]   <= acc_nxt[c];
        short_r[c] <= short_nxt[c];
        err_r[c]   <= err_nxt[c];
        value_r[c] <= value_nxt[c];
      end
      if (in_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
    if (in_fire) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // No item may be taken while a channel period is still being derived.
  a_hold_while_deriving: assert property (@(posedge clk) disable iff (!rst_n)
    (pend_r != '0) |-> !in_ready)
    else $error("item accepted while channel derivation pending");

  // The divider only finishes for a channel that is still marked stale.
  a_done_has_pending: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> pend_r[cur_r])
    else $error("divider finished with no stale channel");

  // A one-shot that fires is disarmed from the next cycle on.
  a_oneshot_disarms: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && res.oneshot_fired) |=> (!os_armed_r && out_valid_r))
    else $error("one-shot still armed after firing");

endmodule

// ===== dv/tb_fractional_rate_tick_timer_core.sv =====
// ----------------------------------------------------------------------------
// Fractional-rate tick timer core testbench
// Drives random and directed items through the timer core and compares every
// result, field by field, with a cycle-free model of the timer.
// ----------------------------------------------------------------------------
module tb_fractional_rate_tick_timer_core;

  import frtt_pkg::*;

  localparam int CLK_PERIOD     = 8;
  localparam int RESET_CYCLES   = 11;
  // The core re-derives channel periods after a register write, one channel at a time.
  localparam int DERIVE_CYCLES  = 60;
  localparam int DRAIN_CYCLES   = 20;
  localparam int RANDOM_PHASES  = 8;
  localparam int PHASE_ITEMS    = 220;
  localparam int BURST_TICKS    = 200;
  localparam int MAX_PRINTED    = 40;
  // The slowest correct run is about 2000 items that each see the longest sender
  // gap and receiver stall, plus the pauses after register writes. The limit lies
  // beyond that.
  localparam int TIMEOUT_CYCLES = 1000000;

  // Action codes that the core does not decode; they behave as a read.
  localparam logic [2:0] ACT_SPARE_LO = 3'd5;
  localparam logic [2:0] ACT_SPARE_HI = 3'd7;

  logic                    clk       = 1'b0;
  logic                    rst_n     = 1'b0;
  logic                    in_valid  = 1'b0;
  logic                    in_ready;
  in_item_t                in_data   = '0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  out_item_t               out_data;
  logic                    cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]    cfg_index = '0;
  logic [CFG_DATA_W-1:0]   cfg_data  = '0;

  // Ticks accepted so far, which is also the core's counter value. The stimulus
  // uses it to aim one-shot targets close to the present time.
  logic [COUNTER_BITS-1:0] ticks_sent = '0;
  // When set, the receiver never stalls.
  logic                    stall_free = 1'b0;
  int unsigned             ready_hold = 0;

  // --------------------------------------------------------------------------
  // Timer model and result store. note_item advances the model by one accepted
  // item and queues the reading that the core must return for it; check_result
  // pops the oldest reading and compares it with what the core produced.
  // --------------------------------------------------------------------------
  class timer_scoreboard;
    logic [2:0]              mode_mask;
    logic [VALUE_W-1:0]      chan_value  [NUM_CHANNELS];
    logic [COUNTER_BITS-1:0] count;
    logic [COUNTER_BITS-1:0] chan_due    [NUM_CHANNELS];
    logic [VALUE_W-1:0]      chan_acc    [NUM_CHANNELS];
    logic [VALUE_W-1:0]      chan_period [NUM_CHANNELS];
    logic [VALUE_W-1:0]      chan_err    [NUM_CHANNELS];
    logic [COUNTER_BITS-1:0] second_due;
    logic [31:0]             epoch;
    logic [COUNTER_BITS-1:0] shot_due;
    logic                    shot_armed;
    out_item_t               expected_readings [$];
    int unsigned             mismatches;
    int unsigned             results_seen;

    function new();
      mode_mask    = '0;
      count        = '0;
      second_due   = COUNTER_BITS'(TICK_RATE);
      epoch        = '0;
      shot_due     = '0;
      shot_armed   = 1'b0;
      mismatches   = 0;
      results_seen = 0;
      for (int c = 0; c < NUM_CHANNELS; c++) begin
        chan_value[c]  = '0;
        chan_due[c]    = CMASK;
        chan_acc[c]    = '0;
        chan_period[c] = '0;
        chan_err[c]    = '0;
      end
    endfunction

    function logic [VALUE_W-1:0] events_per_second(int c);
      return (chan_value[c] > TICK_RATE) ? TICK_RATE : chan_value[c];
    endfunction

    // Periods restart from the present counter value whenever a channel is set up.
    function void rederive(int c);
      logic [VALUE_W-1:0] r;
      chan_acc[c] = '0;
      if (chan_value[c] == '0) begin
        chan_period[c] = '0;
        chan_err[c]    = '0;
        chan_due[c]    = CMASK;
      end else begin
        if (mode_mask[c]) begin
          r              = events_per_second(c);
          chan_period[c] = VALUE_W'(32'(TICK_RATE) / 32'(r));
          chan_err[c]    = VALUE_W'(32'(TICK_RATE) - 32'(chan_period[c]) * 32'(r));
        end else begin
          chan_period[c] = chan_value[c];
          chan_err[c]    = '0;
        end
        chan_due[c] = count + COUNTER_BITS'(chan_period[c]);
      end
    endfunction

    function void apply_setting(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      int ch;
      if (idx == REG_MODE) begin
        mode_mask = data[2:0];
        for (int c = 0; c < NUM_CHANNELS; c++) rederive(c);
      end else begin
        ch = int'(idx) - int'(REG_CH0);
        if (ch < NUM_CHANNELS) begin
          chan_value[ch] = data[VALUE_W-1:0];
          rederive(ch);
        end
      end
    endfunction

    function void note_item(in_item_t it);
      out_item_t               want;
      logic [VALUE_W:0]        advance;
      logic [VALUE_W-1:0]      r;
      logic [COUNTER_BITS-1:0] lead;
      logic [COUNTER_BITS-1:0] elapsed;
      want = '0;
      case (it.action)
        ACT_TICK: begin
          count = count + 1'b1;
          for (int c = 0; c < NUM_CHANNELS; c++) begin
            if (chan_value[c] != '0 && chan_due[c] == count) begin
              advance = {1'b0, chan_period[c]};
              // In rate mode the remainder builds up until one long period is due.
              if (chan_err[c] != '0) begin
                r           = events_per_second(c);
                chan_acc[c] = chan_acc[c] + chan_err[c];
                if (chan_acc[c] >= r) begin
                  chan_acc[c] = chan_acc[c] - r;
                  advance     = advance + 1'b1;
                end
              end
              chan_due[c]            = chan_due[c] + COUNTER_BITS'(advance);
              want.periodic_fired[c] = 1'b1;
            end
          end
          if (second_due == count) begin
            second_due        = second_due + COUNTER_BITS'(TICK_RATE);
            epoch             = epoch + 1'b1;
            want.second_fired = 1'b1;
          end
          if (shot_armed && shot_due == count) begin
            shot_armed         = 1'b0;
            want.oneshot_fired = 1'b1;
          end
        end
        ACT_LOAD_EPOCH: begin
          epoch      = it.epoch_value;
          second_due = count + COUNTER_BITS'(TICK_RATE);
        end
        ACT_ARM: begin
          // A target too close to the present is pushed out to the minimum delay.
          lead       = it.target_tick - count;
          shot_due   = (lead > MIN_DELAY) ? it.target_tick : count + MIN_DELAY;
          shot_armed = 1'b1;
        end
        ACT_STOP: shot_armed = 1'b0;
        default: ;
      endcase
      elapsed               = COUNTER_BITS'(TICK_RATE) + count - second_due;
      want.epoch_seconds    = epoch + 32'(elapsed >> 15);
      want.sub_second_ticks = elapsed[14:0];
      want.tick_count       = 32'(elapsed) + (epoch << 15);
      expected_readings.push_back(want);
    endfunction

    task report(string msg);
      mismatches++;
      if (mismatches <= MAX_PRINTED) $display("MISMATCH result %0d: %s", results_seen, msg);
    endtask

    task compare_field(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want) report($sformatf("%s is %0h, expected %0h", name, got, want));
    endtask

    task check_result(out_item_t got);
      out_item_t want;
      results_seen++;
      if (expected_readings.size() == 0) begin
        report("result with no item outstanding");
      end else begin
        want = expected_readings.pop_front();
        compare_field("periodic_fired", 32'(got.periodic_fired), 32'(want.periodic_fired));
        compare_field("second_fired", 32'(got.second_fired), 32'(want.second_fired));
        compare_field("oneshot_fired", 32'(got.oneshot_fired), 32'(want.oneshot_fired));
        compare_field("epoch_seconds", got.epoch_seconds, want.epoch_seconds);
        compare_field("sub_second_ticks", 32'(got.sub_second_ticks),
                      32'(want.sub_second_ticks));
        compare_field("tick_count", got.tick_count, want.tick_count);
      end
    endtask
  endclass

  timer_scoreboard sb = new();

  fractional_rate_tick_timer_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #(CLK_PERIOD / 2) clk = 1'b1;
    #(CLK_PERIOD / 2) clk = 1'b0;
  end

  // Mostly short gaps, with an occasional long one.
  function automatic int unsigned pick_gap();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 3);
  endfunction

  // The receiver alternates between runs of readiness and stalls of random length.
  always @(posedge clk) begin
    if (ready_hold != 0) begin
      ready_hold <= ready_hold - 1;
    end else if (stall_free || $urandom_range(0, 3) != 0) begin
      out_ready  <= 1'b1;
      ready_hold <= $urandom_range(0, 8);
    end else begin
      out_ready  <= 1'b0;
      ready_hold <= pick_gap() - 1;
    end
  end

  // Both handshakes are observed in one process, so that an item is always
  // recorded before any result at the same edge is checked.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) sb.note_item(in_data);
      if (out_valid && out_ready) sb.check_result(out_data);
    end
  end

  // Presents one item and returns at the edge at which it is taken.
  task automatic drive_item(input in_item_t it);
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    if (it.action == ACT_TICK) ticks_sent = ticks_sent + 1'b1;
  endtask

  task automatic send_op(input logic [2:0] act, input logic [31:0] ev,
                         input logic [COUNTER_BITS-1:0] tgt);
    in_item_t it;
    it.action      = act;
    it.epoch_value = ev;
    it.target_tick = tgt;
    drive_item(it);
  endtask

  task automatic idle_gap(input int unsigned cycles);
    if (cycles != 0) begin
      in_valid <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  // Drops valid and waits until every outstanding result has come back.
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.expected_readings.size() != 0);
  endtask

  // One register write, then a pause long enough for the periods to be re-derived.
  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    sb.apply_setting(idx, data);
    cfg_we <= 1'b0;
    repeat (DERIVE_CYCLES) @(posedge clk);
  endtask

  // Writes every register; the mode goes either first or last, since a mode
  // write re-derives all channels from the values already held.
  task automatic configure(input logic [2:0] mode, input logic [VALUE_W-1:0] v0,
                           input logic [VALUE_W-1:0] v1, input logic [VALUE_W-1:0] v2);
    bit mode_last;
    mode_last = bit'($urandom_range(0, 1));
    if (!mode_last) write_register(REG_MODE, CFG_DATA_W'(mode));
    write_register(REG_CH0, v0);
    write_register(REG_CH0 + 2'd1, v1);
    write_register(REG_CH0 + 2'd2, v2);
    if (mode_last) write_register(REG_MODE, CFG_DATA_W'(mode));
  endtask

  // Channel values: small intervals and high rates, so that channels fire often,
  // with the odd disabled channel and the odd value anywhere in the range.
  function automatic logic [VALUE_W-1:0] pick_value(input bit rate_sel);
    int unsigned roll;
    roll = $urandom_range(0, 15);
    if (roll == 0) return '0;
    if (roll == 1) return VALUE_W'($urandom);
    return rate_sel ? VALUE_W'($urandom_range(800, 32768)) : VALUE_W'($urandom_range(1, 60));
  endfunction

  // Random item: mostly ticks, with one-shots usually aimed a little ahead.
  function automatic in_item_t make_item(input logic [COUNTER_BITS-1:0] now);
    in_item_t    it;
    int unsigned pick;
    it.epoch_value = $urandom;
    it.target_tick = COUNTER_BITS'($urandom);
    pick           = $urandom_range(0, 99);
    if (pick < 70) begin
      it.action = ACT_TICK;
    end else if (pick < 76) begin
      it.action = ACT_LOAD_EPOCH;
    end else if (pick < 86) begin
      it.action = ACT_ARM;
      if ($urandom_range(0, 3) != 0) it.target_tick = now + COUNTER_BITS'($urandom_range(0, 40));
    end else if (pick < 90) begin
      it.action = ACT_STOP;
    end else if (pick < 95) begin
      it.action = ACT_READ;
    end else begin
      it.action = 3'($urandom_range(ACT_SPARE_LO, ACT_SPARE_HI));
    end
    return it;
  endfunction

  initial begin
    logic [2:0] mode;
    bit         quiet;

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part. Channel 0 fires every tick as an interval of one, channel 1
    // has its rate clamped to the tick rate, and channel 2 runs at a rate whose
    // remainder is not zero, so long periods appear.
    configure(3'b110, 16'd1, 16'hFFFF, 16'd10000);
    send_op(ACT_READ, 32'hFFFF_FFFF, CMASK);
    for (int a = ACT_SPARE_LO; a <= ACT_SPARE_HI; a++) begin
      send_op(3'(a), $urandom, COUNTER_BITS'($urandom));
    end
    send_op(ACT_LOAD_EPOCH, '0, '0);
    send_op(ACT_TICK, 32'hFFFF_FFFF, CMASK);
    // A target at the present tick is pushed out to the minimum delay.
    send_op(ACT_ARM, '0, ticks_sent);
    repeat (3) send_op(ACT_TICK, '0, '0);
    // Exactly the minimum delay, then one beyond it, which is taken as given.
    send_op(ACT_ARM, '0, ticks_sent + MIN_DELAY);
    send_op(ACT_ARM, '0, ticks_sent + MIN_DELAY + 1'b1);
    repeat (4) send_op(ACT_TICK, '0, '0);
    // A target just behind the counter lies almost a full wrap ahead.
    send_op(ACT_ARM, '0, ticks_sent - 1'b1);
    send_op(ACT_STOP, '0, '0);
    send_op(ACT_ARM, '0, '0);
    send_op(ACT_ARM, '0, CMASK);
    repeat (2) send_op(ACT_TICK, '0, '0);
    send_op(ACT_STOP, '0, '0);
    send_op(ACT_LOAD_EPOCH, 32'hFFFF_FFFF, '0);
    send_op(ACT_READ, '0, '0);

    // A burst of ticks at full rate with the epoch at its largest value. Rates
    // with non-zero remainders keep the error accumulators busy on the way.
    settle();
    configure(3'b101, 16'd3000, 16'd7, 16'd1500);
    send_op(ACT_LOAD_EPOCH, 32'hFFFF_FFFF, '0);
    stall_free <= 1'b1;
    repeat (BURST_TICKS) send_op(ACT_TICK, $urandom, COUNTER_BITS'($urandom));
    stall_free <= 1'b0;

    // Random phases, each under its own setting. The first three cover the
    // extremes: everything disabled, all channels in rate mode at the clamp, the
    // tick rate and a rate of one, and all channels in interval mode.
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      settle();
      case (phase)
        0: configure(3'b000, '0, '0, '0);
        1: configure(3'b111, 16'hFFFF, 16'h8000, 16'd1);
        2: configure(3'b000, 16'd1, 16'hFFFF, 16'd2);
        default: begin
          mode = 3'($urandom);
          configure(mode, pick_value(mode[0]), pick_value(mode[1]), pick_value(mode[2]));
        end
      endcase
      // Every third phase runs without gaps on either side.
      quiet = (phase % 3 == 2);
      stall_free <= quiet;
      repeat (PHASE_ITEMS) begin
        if (!quiet && $urandom_range(0, 3) == 0) idle_gap(pick_gap());
        drive_item(make_item(ticks_sent));
      end
    end

    settle();
    stall_free <= 1'b0;
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #(CLK_PERIOD * TIMEOUT_CYCLES);
    $display("TIMEOUT waiting for the core");
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
